/* rtl/core/whl_pkg.sv */
// Shared types, constants and codes for the windowed PI heading-lock block.
`default_nettype none

package whl_pkg;

   // Field widths of the channels and the configuration registers.
   localparam int unsigned TargetWidth = 15;
   localparam int unsigned YawWidth    = 16;
   localparam int unsigned DriveWidth  = 19;
   localparam int unsigned GainWidth   = 16;
   localparam int unsigned OffsetWidth = 15;
   localparam int unsigned ThreshWidth = 14;
   localparam int unsigned LimitWidth  = 18;
   localparam int unsigned AddrWidth   = 5;
   localparam int unsigned DataWidth   = 32;

   // Register index, taken from the word address of the configuration port.
   typedef enum logic [2:0] {
      REG_PROP_GAIN    = 3'd0,
      REG_INTEG_GAIN   = 3'd1,
      REG_LEAD_TIME    = 3'd2,
      REG_MOUNT_OFFSET = 3'd3,
      REG_INTEG_START  = 3'd4,
      REG_INTEG_END    = 3'd5,
      REG_INTEG_LIMIT  = 3'd6,
      REG_OUT_LIMIT    = 3'd7
   } reg_idx_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_IMUL,
      ST_IUPD,
      ST_DRIVE
   } state_type;

   // Operand pair selected for the shared multiplier.
   typedef enum logic [1:0] {
      MUL_PRED,
      MUL_INTEG,
      MUL_PROP
   } mul_sel_type;

   // Configuration register contents.
   typedef struct packed {
      logic [GainWidth-1:0]          prop_gain;
      logic [GainWidth-1:0]          integ_gain;
      logic [GainWidth-1:0]          lead_time;
      logic signed [OffsetWidth-1:0] mount_offset;
      logic [ThreshWidth-1:0]        integ_start;
      logic [ThreshWidth-1:0]        integ_end;
      logic [LimitWidth-1:0]         integ_limit;
      logic [LimitWidth-1:0]         out_limit;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_in;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        err_en;
      logic        integ_upd;
      logic        drive_load;
   } cmd_type;

   // Status seen by the controller.
   typedef struct packed {
      logic req_valid;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/whl_ifs.sv */
// Valid/ready channel interfaces for samples and drive results.
`default_nettype none

interface whl_req_if;
   import whl_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [TargetWidth-1:0] target_angle;
   logic signed [YawWidth-1:0]    yaw_rate;

   modport source (output valid, output target_angle, output yaw_rate, input ready);
   modport sink (input valid, input target_angle, input yaw_rate, output ready);
endinterface

interface whl_rsp_if;
   import whl_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DriveWidth-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink (input valid, input drive, output ready);
endinterface

`default_nettype wire

/* rtl/core/whl_csr.sv */
// APB-style configuration register file.
`default_nettype none

module whl_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [whl_pkg::AddrWidth-1:0]   paddr,
   input  wire logic [whl_pkg::DataWidth-1:0]   pwdata,
   output logic      [whl_pkg::DataWidth-1:0]   prdata,
   output logic                                 pready,
   output whl_pkg::cfg_type                     cfg
);
   import whl_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[AddrWidth-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Next register contents on a write transaction.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_PROP_GAIN:    cfg_in.prop_gain    = pwdata[GainWidth-1:0];
            REG_INTEG_GAIN:   cfg_in.integ_gain   = pwdata[GainWidth-1:0];
            REG_LEAD_TIME:    cfg_in.lead_time    = pwdata[GainWidth-1:0];
            REG_MOUNT_OFFSET: cfg_in.mount_offset = $signed(pwdata[OffsetWidth-1:0]);
            REG_INTEG_START:  cfg_in.integ_start  = pwdata[ThreshWidth-1:0];
            REG_INTEG_END:    cfg_in.integ_end    = pwdata[ThreshWidth-1:0];
            REG_INTEG_LIMIT:  cfg_in.integ_limit  = pwdata[LimitWidth-1:0];
            REG_OUT_LIMIT:    cfg_in.out_limit    = pwdata[LimitWidth-1:0];
         endcase
      end
   end

   // Register storage with power-on gains and limits.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= 16'd7680;
         cfg_ff.integ_gain   <= 16'd512;
         cfg_ff.lead_time    <= 16'd0;
         cfg_ff.mount_offset <= 15'sd320;
         cfg_ff.integ_start  <= 14'd13;
         cfg_ff.integ_end    <= 14'd256;
         cfg_ff.integ_limit  <= 18'd57600;
         cfg_ff.out_limit    <= 18'd128000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data, zero-extended to the bus width.
   always_comb begin
      unique case (idx)
         REG_PROP_GAIN:    prdata = {16'd0, cfg_ff.prop_gain};
         REG_INTEG_GAIN:   prdata = {16'd0, cfg_ff.integ_gain};
         REG_LEAD_TIME:    prdata = {16'd0, cfg_ff.lead_time};
         REG_MOUNT_OFFSET: prdata = {17'd0, cfg_ff.mount_offset};
         REG_INTEG_START:  prdata = {18'd0, cfg_ff.integ_start};
         REG_INTEG_END:    prdata = {18'd0, cfg_ff.integ_end};
         REG_INTEG_LIMIT:  prdata = {14'd0, cfg_ff.integ_limit};
         REG_OUT_LIMIT:    prdata = {14'd0, cfg_ff.out_limit};
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/whl_ctrl.sv */
// Sequencing state machine for one sample through the shared multiplier.
`default_nettype none

module whl_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire whl_pkg::status_type status,
   output whl_pkg::cmd_type         cmd,
   output logic                     req_ready
);
   import whl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_ERR;
         end
         ST_ERR:  state_in = ST_IMUL;
         ST_IMUL: state_in = ST_IUPD;
         ST_IUPD: state_in = ST_DRIVE;
         ST_DRIVE: begin
            if (status.out_free) begin
               state_in = status.req_valid ? ST_ERR : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands for the datapath.
   always_comb begin
      cmd        = '0;
      cmd.mul_sel = MUL_PRED;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = status.req_valid;
            cmd.mul_en  = status.req_valid;
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
         end
         ST_IMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INTEG;
         end
         ST_IUPD: begin
            cmd.integ_upd = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_PROP;
         end
         ST_DRIVE: begin
            cmd.drive_load = status.out_free;
            req_ready      = status.out_free;
            cmd.load_in    = status.out_free & status.req_valid;
            cmd.mul_en     = status.out_free & status.req_valid;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/whl_dp.sv */
// Datapath: shared multiplier, error and window logic, integral and output registers.
`default_nettype none

module whl_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire whl_pkg::cfg_type                       cfg,
   input  wire whl_pkg::cmd_type                       cmd,
   input  wire logic signed [whl_pkg::TargetWidth-1:0] target_angle,
   input  wire logic signed [whl_pkg::YawWidth-1:0]    yaw_rate,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_valid,
   output logic signed [whl_pkg::DriveWidth-1:0]       drive,
   output logic                                        out_free
);
   import whl_pkg::*;

   // Saturates a 28-bit sum to plus or minus an unsigned 18-bit limit.
   function automatic logic signed [18:0] clamp_lim(input logic signed [27:0] v,
                                                   input logic [17:0] lim);
      logic signed [27:0] lim_s;
      logic signed [27:0] res;
      lim_s = $signed({10'd0, lim});
      if (v > lim_s) begin
         res = lim_s;
      end else if (v < -lim_s) begin
         res = -lim_s;
      end else begin
         res = v;
      end
      return res[18:0];
   endfunction

   logic signed [TargetWidth-1:0] target_ff;
   logic signed [34:0]            prod_ff;
   logic signed [34:0]            prod_in;
   logic signed [17:0]            error_ff;
   logic signed [19:0]            err_sum;
   logic                          in_window_ff;
   logic                          below_start_ff;
   logic [17:0]                   mag;
   logic signed [18:0]            integ_ff;
   logic signed [18:0]            integ_in;
   logic signed [27:0]            integ_sum;
   logic signed [27:0]            drive_sum;
   logic signed [DriveWidth-1:0]  drive_ff;
   logic                          rsp_valid_ff;
   logic signed [16:0]            mul_a;
   logic signed [17:0]            mul_b;

   // Shared multiplier operand selection.
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_PRED: begin
            mul_a = $signed({1'b0, cfg.lead_time});
            mul_b = {{2{yaw_rate[YawWidth-1]}}, yaw_rate};
         end
         MUL_INTEG: begin
            mul_a = $signed({1'b0, cfg.integ_gain});
            mul_b = error_ff;
         end
         MUL_PROP: begin
            mul_a = $signed({1'b0, cfg.prop_gain});
            mul_b = error_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Heading error: target minus predicted rotation plus mounting offset.
   assign err_sum = {{5{target_ff[TargetWidth-1]}}, target_ff}
                  + {{5{cfg.mount_offset[OffsetWidth-1]}}, cfg.mount_offset}
                  - {prod_ff[34], prod_ff[34:16]};

   // Error magnitude for the integration window.
   assign mag = error_ff[17] ? (~error_ff + 18'd1) : error_ff;

   // Integral step: add the scaled error and clamp to the integral limit.
   assign integ_sum = {prod_ff[34], prod_ff[34:8]} + {{9{integ_ff[18]}}, integ_ff};

   // Inside the window the integral steps, below it clears, otherwise it holds.
   always_comb begin
      integ_in = integ_ff;
      if (cmd.integ_upd) begin
         if (in_window_ff) begin
            integ_in = clamp_lim(integ_sum, cfg.integ_limit);
         end else if (below_start_ff) begin
            integ_in = '0;
         end
      end
   end

   // Output sum of proportional term and integral.
   assign drive_sum = {prod_ff[34], prod_ff[34:8]} + {{9{integ_ff[18]}}, integ_ff};

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_in) target_ff <= target_angle;
      if (cmd.mul_en) prod_ff <= prod_in;
      if (cmd.err_en) error_ff <= err_sum[17:0];
      in_window_ff   <= (mag > {4'd0, cfg.integ_start}) && (mag < {4'd0, cfg.integ_end});
      below_start_ff <= mag < {4'd0, cfg.integ_start};
      if (cmd.drive_load) drive_ff <= clamp_lim(drive_sum, cfg.out_limit);
   end

   // Integral state and output valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         integ_ff <= integ_in;
         if (cmd.drive_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign drive     = drive_ff;

endmodule

`default_nettype wire

/* rtl/core/windowed_pi_heading_lock_top.sv */
// Top level of the windowed PI heading-lock controller.
//
//   Channel   Direction  Handshake           Payload
//   req_chan  in         valid/ready         target_angle, yaw_rate
//   rsp_chan  out        valid/ready         drive
//   psel..    in/out     APB-style, pready=1 8 registers at byte address 4*i
//
// A sample takes these steps in turn: prediction product, error, integral product, then the
// integral update together with the proportional product; the drive register is
// loaded in the cycle that may accept the next sample. One shared 17x18 multiplier,
// used three times per sample, is why these steps of a sample run one after another.
// Reset is synchronous and clears the controller, the integral and the output flag.
// A result held in the output register stalls the block only after the next
// sample has finished its work.
`default_nettype none

module windowed_pi_heading_lock_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   whl_req_if.sink                              req_chan,
   whl_rsp_if.source                            rsp_chan,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [whl_pkg::AddrWidth-1:0]   paddr,
   input  wire logic [whl_pkg::DataWidth-1:0]   pwdata,
   output logic      [whl_pkg::DataWidth-1:0]   prdata,
   output logic                                 pready
);
   import whl_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       out_free;

   // Configuration registers.
   whl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Controller.
   assign status.req_valid = req_chan.valid;
   assign status.out_free  = out_free;

   whl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   assign req_chan.ready = req_ready;

   // Datapath.
   whl_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .target_angle (req_chan.target_angle),
      .yaw_rate     (req_chan.yaw_rate),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .drive        (rsp_chan.drive),
      .out_free     (out_free)
   );

   // An accepted transaction starts the prediction product.
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |-> (cmd.load_in && cmd.mul_en && cmd.mul_sel == MUL_PRED))
      else $error("accepted sample did not load the datapath");

   // The error stage follows a load, and the integral product follows the error.
   a_sequence: assert property (@(posedge clock) disable iff (reset)
      cmd.load_in |=> cmd.err_en ##1 (cmd.mul_en && cmd.mul_sel == MUL_INTEG))
      else $error("sample sequence broken after load");

   // The output register is never overwritten while a result is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.drive_load |-> out_free)
      else $error("drive loaded while previous result pending");

   // A new result appears only after a drive load.
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.drive_load))
      else $error("result valid without drive load");

endmodule

`default_nettype wire

/* tb/whl_tb_pkg.sv */
// Scoreboard class that predicts and checks drive commands of the heading-lock block.
package whl_tb_pkg;
   import whl_pkg::*;

   class drive_checker;
      cfg_type                      cfg;
      logic signed [DriveWidth-1:0] integ_sum;
      logic signed [DriveWidth-1:0] expected_drives[$];
      int unsigned                  errors;

      // Registers and the integral start from their reset values.
      function new();
         cfg.prop_gain    = 16'd7680;
         cfg.integ_gain   = 16'd512;
         cfg.lead_time    = 16'd0;
         cfg.mount_offset = 15'sd320;
         cfg.integ_start  = 14'd13;
         cfg.integ_end    = 14'd256;
         cfg.integ_limit  = 18'd57600;
         cfg.out_limit    = 18'd128000;
         integ_sum        = '0;
         errors           = 0;
      endfunction

      // Mirror a register write; bits above the register width are dropped.
      function void write_reg(reg_idx_type idx, logic [DataWidth-1:0] word);
         case (idx)
            REG_PROP_GAIN:    cfg.prop_gain    = word[GainWidth-1:0];
            REG_INTEG_GAIN:   cfg.integ_gain   = word[GainWidth-1:0];
            REG_LEAD_TIME:    cfg.lead_time    = word[GainWidth-1:0];
            REG_MOUNT_OFFSET: cfg.mount_offset = word[OffsetWidth-1:0];
            REG_INTEG_START:  cfg.integ_start  = word[ThreshWidth-1:0];
            REG_INTEG_END:    cfg.integ_end    = word[ThreshWidth-1:0];
            REG_INTEG_LIMIT:  cfg.integ_limit  = word[LimitWidth-1:0];
            REG_OUT_LIMIT:    cfg.out_limit    = word[LimitWidth-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_to(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      // Work out the drive command for one accepted sample and queue it.
      function void add_sample(logic signed [TargetWidth-1:0] target,
                               logic signed [YawWidth-1:0] yaw);
         longint pred, err, mag, start_th, end_th, sum, pterm, drv;
         pred     = (longint'(cfg.lead_time) * longint'(yaw)) >>> 16;
         err      = longint'(target) - pred + longint'($signed(cfg.mount_offset));
         mag      = (err < 0) ? -err : err;
         start_th = longint'(cfg.integ_start);
         end_th   = longint'(cfg.integ_end);

         // Integrate only strictly inside the window, clear below it, else hold.
         if (mag > start_th && mag < end_th) begin
            sum = longint'(integ_sum) + ((longint'(cfg.integ_gain) * err) >>> 8);
            sum = clamp_to(sum, longint'(cfg.integ_limit));
            integ_sum = sum[DriveWidth-1:0];
         end else if (mag < start_th) begin
            integ_sum = '0;
         end

         pterm = (longint'(cfg.prop_gain) * err) >>> 8;
         drv   = clamp_to(pterm + longint'(integ_sum), longint'(cfg.out_limit));
         expected_drives.push_back(drv[DriveWidth-1:0]);
      endfunction

      // Compare one drive result with the oldest prediction.
      function void check_drive(logic signed [DriveWidth-1:0] actual);
         logic signed [DriveWidth-1:0] want;
         if (expected_drives.size() == 0) begin
            $display("%0t: drive result %0d arrived with no sample pending", $time, actual);
            errors++;
         end else begin
            want = expected_drives.pop_front();
            if (actual !== want) begin
               $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench for the windowed PI heading-lock controller.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import whl_pkg::*;
   import whl_tb_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned ItemsPerPhase = 50;
   localparam int unsigned RandomPhases = 8;

   logic                 clock;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [AddrWidth-1:0] paddr;
   logic [DataWidth-1:0] pwdata;
   logic [DataWidth-1:0] prdata;
   logic                 pready;

   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned cycles;

   drive_checker chk = new();

   whl_req_if req_chan();
   whl_rsp_if rsp_chan();

   windowed_pi_heading_lock_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Clock with a 2 ns period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog on the total run length.
   initial begin
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver side: stall the result channel at the rate of the current phase.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Monitors: every accepted transaction on either channel goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            chk.add_sample(req_chan.target_angle, req_chan.yaw_rate);
         if (rsp_chan.valid && rsp_chan.ready)
            chk.check_drive(rsp_chan.drive);
      end
   end

   // One register write: setup phase, then access phase, then the bus returns to idle.
   // Bits above the register width sometimes carry noise.
   task automatic csr_write(reg_idx_type idx, logic [DataWidth-1:0] field, int width);
      logic [DataWidth-1:0] mask;
      logic [DataWidth-1:0] noise;
      logic [DataWidth-1:0] word;
      mask  = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
      noise = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      word  = (field & mask) | (noise & ~mask);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      chk.write_reg(idx, word);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one sample after a random gap and hold it until the block takes it.
   task automatic send_sample(logic signed [TargetWidth-1:0] target,
                              logic signed [YawWidth-1:0] yaw);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.target_angle <= target;
      req_chan.yaw_rate     <= yaw;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stop sending and wait until every predicted drive has been checked.
   // The first edge lets the monitor record the last accepted sample.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (chk.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 49; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 49; end
         default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
   endtask

   // Load a full register set: full-scale gains and limits, zero gains and limits, or random.
   task automatic config_phase(int kind);
      int unsigned start_th;
      int unsigned end_th;
      case (kind)
         1: begin
            csr_write(REG_PROP_GAIN, 65535, GainWidth);
            csr_write(REG_INTEG_GAIN, 65535, GainWidth);
            csr_write(REG_LEAD_TIME, 65535, GainWidth);
            csr_write(REG_MOUNT_OFFSET, 11520, OffsetWidth);
            csr_write(REG_INTEG_START, 0, ThreshWidth);
            csr_write(REG_INTEG_END, 11520, ThreshWidth);
            csr_write(REG_INTEG_LIMIT, 262143, LimitWidth);
            csr_write(REG_OUT_LIMIT, 262143, LimitWidth);
         end
         2: begin
            csr_write(REG_PROP_GAIN, 0, GainWidth);
            csr_write(REG_INTEG_GAIN, 0, GainWidth);
            csr_write(REG_LEAD_TIME, 0, GainWidth);
            csr_write(REG_MOUNT_OFFSET, -11520, OffsetWidth);
            csr_write(REG_INTEG_START, 0, ThreshWidth);
            csr_write(REG_INTEG_END, 0, ThreshWidth);
            csr_write(REG_INTEG_LIMIT, 0, LimitWidth);
            csr_write(REG_OUT_LIMIT, 0, LimitWidth);
         end
         default: begin
            start_th = $urandom_range(0, 400);
            end_th   = start_th + $urandom_range(0, 2000);
            // Now and then the window is empty.
            if ($urandom_range(0, 4) == 0) begin
               end_th   = start_th;
               start_th = start_th + $urandom_range(0, 300);
            end
            csr_write(REG_PROP_GAIN, $urandom_range(0, 65535), GainWidth);
            csr_write(REG_INTEG_GAIN, $urandom_range(0, 65535), GainWidth);
            csr_write(REG_LEAD_TIME, ($urandom_range(0, 1) == 0) ?
                      $urandom_range(0, 2000) : $urandom_range(0, 65535), GainWidth);
            csr_write(REG_MOUNT_OFFSET, $urandom, OffsetWidth);
            csr_write(REG_INTEG_START, start_th, ThreshWidth);
            csr_write(REG_INTEG_END, end_th, ThreshWidth);
            csr_write(REG_INTEG_LIMIT, $urandom, LimitWidth);
            csr_write(REG_OUT_LIMIT, $urandom, LimitWidth);
         end
      endcase
   endtask

   // Random samples, most of them aimed so the error lands near the window.
   task automatic random_phase(int unsigned count);
      logic signed [YawWidth-1:0]    yaw;
      logic signed [TargetWidth-1:0] target;
      logic [31:0]                   rnd;
      longint                        pred;
      longint                        err;
      longint                        reach;
      longint                        tgt;
      for (int unsigned i = 0; i < count; i++) begin
         rnd = $urandom;
         yaw = rnd[YawWidth-1:0];
         if ($urandom_range(0, 99) < 70) begin
            reach = longint'(chk.cfg.integ_end);
            if (longint'(chk.cfg.integ_start) > reach) reach = longint'(chk.cfg.integ_start);
            err  = longint'($urandom_range(0, int'(reach) + 20));
            if ($urandom_range(0, 1) == 1) err = -err;
            pred = (longint'(chk.cfg.lead_time) * longint'(yaw)) >>> 16;
            tgt  = err - longint'($signed(chk.cfg.mount_offset)) + pred;
            target = tgt[TargetWidth-1:0];
         end else begin
            rnd    = $urandom;
            target = rnd[TargetWidth-1:0];
         end
         send_sample(target, yaw);
      end
   endtask

   // Main sequence.
   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.target_angle = '0;
      req_chan.yaw_rate     = '0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      set_idling(0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: error equals target plus 320 since the lead time is zero.
      send_sample(0, 0);              // above the window, held
      send_sample(-200, 32767);       // inside, integrates
      send_sample(-200, -32768);      // inside, integrates
      send_sample(-307, 0);           // exactly on start, held
      send_sample(-333, 0);           // exactly on start, negative side
      send_sample(-64, 0);            // exactly on end, held
      send_sample(-576, 0);           // exactly on end, negative side
      send_sample(-320, 0);           // zero error clears
      send_sample(-315, 0);           // below start clears
      set_idling(3);
      send_sample(16383, 32767);
      send_sample(-16384, -32768);
      send_sample(11520, 0);
      send_sample(-11520, 0);
      drain();

      // Every register at an extreme, with a full-scale lead time.
      csr_write(REG_PROP_GAIN, 65535, GainWidth);
      csr_write(REG_INTEG_GAIN, 65535, GainWidth);
      csr_write(REG_LEAD_TIME, 65535, GainWidth);
      csr_write(REG_MOUNT_OFFSET, 15'h4000, OffsetWidth);
      csr_write(REG_INTEG_START, 0, ThreshWidth);
      csr_write(REG_INTEG_END, 16383, ThreshWidth);
      csr_write(REG_INTEG_LIMIT, 262143, LimitWidth);
      csr_write(REG_OUT_LIMIT, 262143, LimitWidth);
      send_sample(16383, -32768);
      send_sample(-16384, 32767);
      send_sample(0, 100);
      send_sample(16383, 0);
      send_sample(100, 0);
      drain();

      // Limit lowered while the integral is held, then clamped by the next step.
      csr_write(REG_MOUNT_OFFSET, 0, OffsetWidth);
      csr_write(REG_INTEG_END, 1000, ThreshWidth);
      csr_write(REG_INTEG_LIMIT, 50, LimitWidth);
      send_sample(2000, 0);
      send_sample(500, 0);
      drain();

      // Start above end: the window is empty.
      csr_write(REG_INTEG_START, 300, ThreshWidth);
      csr_write(REG_INTEG_END, 200, ThreshWidth);
      send_sample(250, 0);
      send_sample(300, 0);
      send_sample(-5000, 0);
      send_sample(100, 0);
      send_sample(250, 0);
      drain();

      // Random phases, each with its own settings and idling pattern.
      for (int p = 0; p < RandomPhases; p++) begin
         set_idling(p % 4);
         config_phase((p == 2) ? 1 : ((p == 5) ? 2 : 0));
         random_phase(ItemsPerPhase);
         drain();
      end

      repeat (20) @(posedge clock);
      if (chk.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
rtl/core/whl_pkg.sv
rtl/core/whl_ifs.sv
rtl/core/whl_csr.sv
rtl/core/whl_ctrl.sv
rtl/core/whl_dp.sv
rtl/core/windowed_pi_heading_lock_top.sv
tb/whl_tb_pkg.sv
tb/tb_top.sv
